### rtl/ft12_pkg.sv
// shared types, codes and constants of the ft1.2 frame receiver
`timescale 1ns / 1ps

package ft12_pkg;

    localparam int BUFFER_DEPTH_DEF = 512;
    localparam int MAX_RESULTS      = 8;
    localparam int OFF_W            = 9;

    localparam logic [7:0] BYTE_ACK   = 8'hE5;
    localparam logic [7:0] BYTE_SHORT = 8'h10;
    localparam logic [7:0] BYTE_LONG  = 8'h68;
    localparam logic [7:0] BYTE_END   = 8'h16;
    localparam logic [7:0] CTL_F3     = 8'hF3;
    localparam logic [7:0] CTL_D3     = 8'hD3;
    localparam logic [7:0] DATA_RESET = 8'hA0;
    localparam logic [3:0] NIB_ZERO   = 4'h0;

    localparam logic OP_LINE = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        EV_SEND_ACK = 3'd0,
        EV_ACK_RX   = 3'd1,
        EV_RESET    = 3'd2,
        EV_DELIVER  = 3'd3,
        EV_READ     = 3'd4
    } ev_t;

    typedef enum logic [2:0] {
        OFF_0,
        OFF_1,
        OFF_2,
        OFF_3,
        OFF_4,
        OFF_LSUM,
        OFF_LEND
    } off_sel_t;

    typedef enum logic [1:0] {
        DROP_NONE,
        DROP_1,
        DROP_4,
        DROP_TOTAL
    } drop_t;

    typedef enum logic [1:0] {
        WALK_SUM,
        WALK_CMP,
        WALK_COPY
    } walk_mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_PAY,
        ST_SCAN,
        ST_DEC,
        ST_EM_ACKRX,
        ST_SH_C1,
        ST_SH_C2,
        ST_SH_C3,
        ST_EM_SACK,
        ST_EM_RST,
        ST_LG_L1,
        ST_LG_L2,
        ST_LG_L3,
        ST_LG_SUM,
        ST_LG_CK1,
        ST_LG_CK2,
        ST_EM_LACK,
        ST_LG_CTL,
        ST_LG_CMP,
        ST_LG_CMPEND,
        ST_LG_COPY,
        ST_EM_DEL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       acc_line;
        logic       acc_read;
        logic       rd_en;
        off_sel_t   off_sel;
        logic       cap_c;
        logic       cap_eq;
        logic       cap_sum_ok;
        drop_t      drop;
        logic       seq_short;
        logic       seq_toggle;
        logic       clr_waiting;
        logic       walk_start;
        walk_mode_t walk_mode;
        logic       walk_en;
        logic       diff_init;
        logic       set_dlen;
        logic       emit;
        ev_t        emit_ev;
        logic       finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       count_zero;
        logic       count_lt4;
        logic       count_lt7;
        logic       count_lt_total;
        logic       eq;
        logic       c_nib_zero;
        logic       l_zero;
        logic       plen_zero;
        logic       len_ne;
        logic       ctl_rep;
        logic       ctl_nxt;
        logic       differ;
        logic       walk_done;
        logic       emit_ready;
        logic       waiting;
    } dp_status_t;

endpackage

### rtl/ft12_frame_receiver.sv
// top level of the ft1.2 serial frame receiver
//
//  channel | handshake            | fields
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | opcode, rx_byte, ack_expected, read_index
//  output  | out_valid / out_stall| event_res, data, frame_length, last
//
// one transaction at a time; a read returns one payload byte, a line byte is
// stored and the buffer rescanned, dropping bytes, acknowledging short frames
// (with a reset indication) and checking long frames with a payload compare or copy
// the single-port frame buffer read is what paces the rescan
// no clearing pass after reset; the block is ready on the first cycle
// a stalled output holds the scan at its next result until taken
`timescale 1ns / 1ps

module ft12_frame_receiver #(
    parameter int BUFFER_DEPTH = ft12_pkg::BUFFER_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       opcode,
    input  logic [7:0] rx_byte,
    input  logic       ack_expected,
    input  logic [7:0] read_index,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [7:0] data,
    output logic [7:0] frame_length,
    output logic       last
);

    ft12_pkg::ctrl_cmd_t  cmd;
    ft12_pkg::dp_status_t status;

    ft12_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .opcode   (opcode),
        .status   (status),
        .cmd      (cmd)
    );

    ft12_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .rx_byte      (rx_byte),
        .ack_expected (ack_expected),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .data         (data),
        .frame_length (frame_length),
        .last         (last)
    );

endmodule

### rtl/ft12_datapath.sv
// frame buffer, payload store, scan registers and result staging
`timescale 1ns / 1ps

module ft12_datapath #(
    parameter int BUFFER_DEPTH = ft12_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ft12_pkg::ctrl_cmd_t   cmd,
    output ft12_pkg::dp_status_t  status,
    input  logic [7:0]            rx_byte,
    input  logic                  ack_expected,
    input  logic [7:0]            read_index,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            event_res,
    output logic [7:0]            data,
    output logic [7:0]            frame_length,
    output logic                  last
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int OW = ft12_pkg::OFF_W;
    localparam logic [SW-1:0] DEPTH_S = SW'(BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
    localparam logic [3:0]    MAX_N   = 4'(ft12_pkg::MAX_RESULTS);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                                input logic [SW-1:0] off);
        logic [SW-1:0] s;
        s = {1'b0, base} + off;
        if (s >= DEPTH_S)
        begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    logic [7:0] fmem [BUFFER_DEPTH];
    logic [7:0] pmem [256];

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic          seq_reg;
    logic [7:0]    dlen_reg;
    logic          waiting_reg;
    logic [7:0]    c_reg;
    logic          eq_reg;
    logic [7:0]    sum_reg;
    logic          differ_reg;
    logic [OW-1:0] idx_reg;
    logic [OW-1:0] end_reg;
    logic          pend_reg;
    logic [7:0]    pidx_reg;
    ft12_pkg::walk_mode_t mode_reg;
    logic [3:0]    n_reg;
    logic          pend_valid_reg;
    logic [2:0]    pend_ev_reg;
    logic [7:0]    pend_data_reg;
    logic [7:0]    pend_len_reg;
    logic          out_valid_reg;
    logic [2:0]    out_ev_reg;
    logic [7:0]    out_data_reg;
    logic [7:0]    out_len_reg;
    logic          out_last_reg;
    logic [7:0]    rdata_reg;
    logic [7:0]    pay_rdata_reg;

    logic [OW-1:0] fixed_off;
    logic [OW-1:0] frd_off;
    logic [OW-1:0] total;
    logic [OW-1:0] drop_n;
    logic [OW-1:0] idx_m5;
    logic [AW-1:0] frd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    paddr;
    logic [7:0]    plen;
    logic          walk_issue;
    logic          frd_en;
    logic          pay_rd_en;
    logic          buf_full;
    logic          out_free;
    logic          emit_ready;
    logic          do_emit;
    logic          do_fin;
    logic [7:0]    new_data;
    logic [7:0]    new_len;

    assign total      = {1'b0, c_reg} + OW'(6);
    assign plen       = c_reg - 8'd1;
    assign idx_m5     = idx_reg - OW'(5);
    assign walk_issue = cmd.walk_en && (idx_reg < end_reg);
    assign frd_en     = cmd.rd_en || walk_issue;
    assign frd_off    = walk_issue ? idx_reg : fixed_off;
    assign frd_addr   = wrap_add(head_reg, SW'(frd_off));
    assign wr_addr    = wrap_add(head_reg, SW'(count_reg));
    assign buf_full   = (count_reg == DEPTH_C);
    assign paddr      = cmd.acc_read ? read_index : idx_m5[7:0];
    assign pay_rd_en  = cmd.acc_read || (walk_issue && mode_reg == ft12_pkg::WALK_CMP);
    assign out_free   = !out_valid_reg || !out_stall;
    assign emit_ready = !pend_valid_reg || out_free;
    assign do_emit    = cmd.emit && emit_ready && (n_reg < MAX_N);
    assign do_fin     = cmd.finish && emit_ready && pend_valid_reg;

    always_comb
    begin
        case (cmd.off_sel)
            ft12_pkg::OFF_0:    fixed_off = OW'(0);
            ft12_pkg::OFF_1:    fixed_off = OW'(1);
            ft12_pkg::OFF_2:    fixed_off = OW'(2);
            ft12_pkg::OFF_3:    fixed_off = OW'(3);
            ft12_pkg::OFF_4:    fixed_off = OW'(4);
            ft12_pkg::OFF_LSUM: fixed_off = {1'b0, c_reg} + OW'(4);
            ft12_pkg::OFF_LEND: fixed_off = {1'b0, c_reg} + OW'(5);
            default:            fixed_off = OW'(0);
        endcase
    end

    always_comb
    begin
        case (cmd.drop)
            ft12_pkg::DROP_1:     drop_n = OW'(1);
            ft12_pkg::DROP_4:     drop_n = OW'(4);
            ft12_pkg::DROP_TOTAL: drop_n = total;
            default:              drop_n = OW'(0);
        endcase
    end

    always_comb
    begin
        case (cmd.emit_ev)
            ft12_pkg::EV_SEND_ACK:
            begin
                new_data = ft12_pkg::BYTE_ACK;
                new_len  = 8'd0;
            end
            ft12_pkg::EV_RESET:
            begin
                new_data = ft12_pkg::DATA_RESET;
                new_len  = 8'd0;
            end
            ft12_pkg::EV_DELIVER:
            begin
                new_data = 8'd0;
                new_len  = plen;
            end
            ft12_pkg::EV_READ:
            begin
                new_data = pay_rdata_reg;
                new_len  = dlen_reg;
            end
            default:
            begin
                new_data = 8'd0;
                new_len  = 8'd0;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.acc_line && !buf_full)
        begin
            fmem[wr_addr] <= rx_byte;
        end
        if (frd_en)
        begin
            rdata_reg <= fmem[frd_addr];
        end
        if (pay_rd_en)
        begin
            pay_rdata_reg <= pmem[paddr];
        end
        if (pend_reg && mode_reg == ft12_pkg::WALK_COPY)
        begin
            pmem[pidx_reg] <= rdata_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            seq_reg        <= 1'b0;
            dlen_reg       <= 8'd0;
            waiting_reg    <= 1'b0;
            n_reg          <= 4'd0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.acc_line || cmd.acc_read)
            begin
                waiting_reg <= ack_expected;
                n_reg       <= 4'd0;
            end
            else if (cmd.clr_waiting)
            begin
                waiting_reg <= 1'b0;
            end
            if (cmd.acc_line && !buf_full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.drop != ft12_pkg::DROP_NONE)
            begin
                head_reg  <= wrap_add(head_reg, SW'(drop_n));
                count_reg <= count_reg - CW'(drop_n);
            end
            if (cmd.seq_short)
            begin
                if ((c_reg == ft12_pkg::CTL_F3 && !seq_reg) ||
                    (c_reg == ft12_pkg::CTL_D3 && seq_reg))
                begin
                    seq_reg <= !seq_reg;
                end
            end
            else if (cmd.seq_toggle)
            begin
                seq_reg <= !seq_reg;
            end
            if (cmd.set_dlen)
            begin
                dlen_reg <= plen;
            end
            pend_reg <= walk_issue;
            if (do_emit)
            begin
                pend_valid_reg <= 1'b1;
                n_reg          <= n_reg + 4'd1;
            end
            else if (do_fin)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((do_emit && pend_valid_reg) || do_fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // scan and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.cap_c)
        begin
            c_reg <= rdata_reg;
        end
        if (cmd.cap_eq)
        begin
            eq_reg <= (rdata_reg == c_reg);
        end
        else if (cmd.cap_sum_ok)
        begin
            eq_reg <= (rdata_reg == sum_reg);
        end
        if (cmd.walk_start)
        begin
            mode_reg <= cmd.walk_mode;
            idx_reg  <= (cmd.walk_mode == ft12_pkg::WALK_SUM) ? OW'(4) : OW'(5);
            end_reg  <= {1'b0, c_reg} + OW'(4);
            sum_reg  <= 8'd0;
        end
        else if (cmd.walk_en)
        begin
            if (walk_issue)
            begin
                idx_reg  <= idx_reg + OW'(1);
                pidx_reg <= idx_m5[7:0];
            end
            if (pend_reg && mode_reg == ft12_pkg::WALK_SUM)
            begin
                sum_reg <= sum_reg + rdata_reg;
            end
        end
        if (cmd.diff_init)
        begin
            differ_reg <= (plen != dlen_reg);
        end
        else if (cmd.walk_en && pend_reg && mode_reg == ft12_pkg::WALK_CMP &&
                 rdata_reg != pay_rdata_reg)
        begin
            differ_reg <= 1'b1;
        end
        if (do_emit)
        begin
            pend_ev_reg   <= cmd.emit_ev;
            pend_data_reg <= new_data;
            pend_len_reg  <= new_len;
        end
        if ((do_emit && pend_valid_reg) || do_fin)
        begin
            out_ev_reg   <= pend_ev_reg;
            out_data_reg <= pend_data_reg;
            out_len_reg  <= pend_len_reg;
            out_last_reg <= do_fin;
        end
    end

    always_comb
    begin
        status.rdata          = rdata_reg;
        status.count_zero     = (count_reg == '0);
        status.count_lt4      = (count_reg < CW'(4));
        status.count_lt7      = (count_reg < CW'(7));
        status.count_lt_total = (count_reg < CW'(total));
        status.eq             = eq_reg;
        status.c_nib_zero     = (c_reg[3:0] == ft12_pkg::NIB_ZERO);
        status.l_zero         = (c_reg == 8'd0);
        status.plen_zero      = (c_reg == 8'd1);
        status.len_ne         = (plen != dlen_reg);
        status.ctl_rep        = (rdata_reg == (seq_reg ? ft12_pkg::CTL_F3 : ft12_pkg::CTL_D3));
        status.ctl_nxt        = (rdata_reg == (seq_reg ? ft12_pkg::CTL_D3 : ft12_pkg::CTL_F3));
        status.differ         = differ_reg;
        status.walk_done      = !walk_issue && !pend_reg;
        status.emit_ready     = emit_ready;
        status.waiting        = waiting_reg;
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_ev_reg;
    assign data         = out_data_reg;
    assign frame_length = out_len_reg;
    assign last         = out_last_reg;

endmodule

### rtl/ft12_controller.sv
// frame scan sequencer of the ft1.2 frame receiver
`timescale 1ns / 1ps

module ft12_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  ft12_pkg::dp_status_t  status,
    output ft12_pkg::ctrl_cmd_t   cmd
);

    ft12_pkg::state_t state_reg;
    ft12_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ft12_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = (state_reg != ft12_pkg::ST_IDLE);
        case (state_reg)
            ft12_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == ft12_pkg::OP_READ)
                    begin
                        cmd.acc_read = 1'b1;
                        state_next   = ft12_pkg::ST_RD_PAY;
                    end
                    else
                    begin
                        cmd.acc_line = 1'b1;
                        state_next   = ft12_pkg::ST_SCAN;
                    end
                end
            end
            ft12_pkg::ST_RD_PAY:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ev = ft12_pkg::EV_READ;
                if (status.emit_ready)
                begin
                    state_next = ft12_pkg::ST_FINISH;
                end
            end
            ft12_pkg::ST_SCAN:
            begin
                if (status.count_zero)
                begin
                    state_next = ft12_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.off_sel = ft12_pkg::OFF_0;
                    state_next  = ft12_pkg::ST_DEC;
                end
            end
            ft12_pkg::ST_DEC:
            begin
                if (status.rdata == ft12_pkg::BYTE_ACK)
                begin
                    if (status.waiting)
                    begin
                        state_next = ft12_pkg::ST_EM_ACKRX;
                    end
                    else
                    begin
                        cmd.drop   = ft12_pkg::DROP_1;
                        state_next = ft12_pkg::ST_SCAN;
                    end
                end
                else if (status.rdata == ft12_pkg::BYTE_SHORT)
                begin
                    if (status.count_lt4)
                    begin
                        state_next = ft12_pkg::ST_FINISH;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.off_sel = ft12_pkg::OFF_1;
                        state_next  = ft12_pkg::ST_SH_C1;
                    end
                end
                else if (status.rdata == ft12_pkg::BYTE_LONG)
                begin
                    if (status.count_lt7)
                    begin
                        state_next = ft12_pkg::ST_FINISH;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.off_sel = ft12_pkg::OFF_1;
                        state_next  = ft12_pkg::ST_LG_L1;
                    end
                end
                else
                begin
                    cmd.drop   = ft12_pkg::DROP_1;
                    state_next = ft12_pkg::ST_SCAN;
                end
            end
            ft12_pkg::ST_EM_ACKRX:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ev = ft12_pkg::EV_ACK_RX;
                if (status.emit_ready)
                begin
                    cmd.clr_waiting = 1'b1;
                    cmd.drop        = ft12_pkg::DROP_1;
                    state_next      = ft12_pkg::ST_SCAN;
                end
            end
            ft12_pkg::ST_SH_C1:
            begin
                cmd.cap_c   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.off_sel = ft12_pkg::OFF_2;
                state_next  = ft12_pkg::ST_SH_C2;
            end
            ft12_pkg::ST_SH_C2:
            begin
                cmd.cap_eq  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.off_sel = ft12_pkg::OFF_3;
                state_next  = ft12_pkg::ST_SH_C3;
            end
            ft12_pkg::ST_SH_C3:
            begin
                if (status.eq && status.rdata == ft12_pkg::BYTE_END)
                begin
                    cmd.seq_short = 1'b1;
                    state_next    = ft12_pkg::ST_EM_SACK;
                end
                else
                begin
                    cmd.drop   = ft12_pkg::DROP_1;
                    state_next = ft12_pkg::ST_SCAN;
                end
            end
            ft12_pkg::ST_EM_SACK:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ev = ft12_pkg::EV_SEND_ACK;
                if (status.emit_ready)
                begin
                    if (status.c_nib_zero)
                    begin
                        state_next = ft12_pkg::ST_EM_RST;
                    end
                    else
                    begin
                        cmd.drop   = ft12_pkg::DROP_4;
                        state_next = ft12_pkg::ST_SCAN;
                    end
                end
            end
            ft12_pkg::ST_EM_RST:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ev = ft12_pkg::EV_RESET;
                if (status.emit_ready)
                begin
                    cmd.drop   = ft12_pkg::DROP_4;
                    state_next = ft12_pkg::ST_SCAN;
                end
            end
            ft12_pkg::ST_LG_L1:
            begin
                cmd.cap_c   = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.off_sel = ft12_pkg::OFF_2;
                state_next  = ft12_pkg::ST_LG_L2;
            end
            ft12_pkg::ST_LG_L2:
            begin
                cmd.cap_eq  = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.off_sel = ft12_pkg::OFF_3;
                state_next  = ft12_pkg::ST_LG_L3;
            end
            ft12_pkg::ST_LG_L3:
            begin
                if (!(status.eq && status.rdata == ft12_pkg::BYTE_LONG))
                begin
                    cmd.drop   = ft12_pkg::DROP_1;
                    state_next = ft12_pkg::ST_SCAN;
                end
                else if (status.count_lt_total)
                begin
                    state_next = ft12_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.walk_start = 1'b1;
                    cmd.walk_mode  = ft12_pkg::WALK_SUM;
                    state_next     = ft12_pkg::ST_LG_SUM;
                end
            end
            ft12_pkg::ST_LG_SUM:
            begin
                cmd.walk_en   = 1'b1;
                cmd.walk_mode = ft12_pkg::WALK_SUM;
                if (status.walk_done)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.off_sel = ft12_pkg::OFF_LSUM;
                    state_next  = ft12_pkg::ST_LG_CK1;
                end
            end
            ft12_pkg::ST_LG_CK1:
            begin
                cmd.cap_sum_ok = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.off_sel    = ft12_pkg::OFF_LEND;
                state_next     = ft12_pkg::ST_LG_CK2;
            end
            ft12_pkg::ST_LG_CK2:
            begin
                if (status.eq && status.rdata == ft12_pkg::BYTE_END)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.off_sel = ft12_pkg::OFF_4;
                    state_next  = ft12_pkg::ST_EM_LACK;
                end
                else
                begin
                    cmd.drop   = ft12_pkg::DROP_TOTAL;
                    state_next = ft12_pkg::ST_SCAN;
                end
            end
            ft12_pkg::ST_EM_LACK:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ev = ft12_pkg::EV_SEND_ACK;
                if (status.emit_ready)
                begin
                    state_next = ft12_pkg::ST_LG_CTL;
                end
            end
            ft12_pkg::ST_LG_CTL:
            begin
                if (status.l_zero)
                begin
                    cmd.drop   = ft12_pkg::DROP_TOTAL;
                    state_next = ft12_pkg::ST_SCAN;
                end
                else if (status.ctl_rep)
                begin
                    cmd.diff_init = 1'b1;
                    if (status.len_ne || status.plen_zero)
                    begin
                        state_next = ft12_pkg::ST_LG_CMPEND;
                    end
                    else
                    begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_mode  = ft12_pkg::WALK_CMP;
                        state_next     = ft12_pkg::ST_LG_CMP;
                    end
                end
                else if (status.ctl_nxt)
                begin
                    cmd.seq_toggle = 1'b1;
                    cmd.walk_start = 1'b1;
                    cmd.walk_mode  = ft12_pkg::WALK_COPY;
                    state_next     = ft12_pkg::ST_LG_COPY;
                end
                else
                begin
                    cmd.drop   = ft12_pkg::DROP_TOTAL;
                    state_next = ft12_pkg::ST_SCAN;
                end
            end
            ft12_pkg::ST_LG_CMP:
            begin
                cmd.walk_en   = 1'b1;
                cmd.walk_mode = ft12_pkg::WALK_CMP;
                if (status.walk_done)
                begin
                    state_next = ft12_pkg::ST_LG_CMPEND;
                end
            end
            ft12_pkg::ST_LG_CMPEND:
            begin
                cmd.seq_toggle = status.differ;
                cmd.drop       = ft12_pkg::DROP_TOTAL;
                state_next     = ft12_pkg::ST_SCAN;
            end
            ft12_pkg::ST_LG_COPY:
            begin
                cmd.walk_en   = 1'b1;
                cmd.walk_mode = ft12_pkg::WALK_COPY;
                if (status.walk_done)
                begin
                    cmd.set_dlen = 1'b1;
                    state_next   = ft12_pkg::ST_EM_DEL;
                end
            end
            ft12_pkg::ST_EM_DEL:
            begin
                cmd.emit    = 1'b1;
                cmd.emit_ev = ft12_pkg::EV_DELIVER;
                if (status.emit_ready)
                begin
                    cmd.drop   = ft12_pkg::DROP_TOTAL;
                    state_next = ft12_pkg::ST_SCAN;
                end
            end
            ft12_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                if (status.emit_ready)
                begin
                    state_next = ft12_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ft12_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
